// File: sv/lav_pkg.sv
package lav_pkg;

   // Number formats
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int FW = 32;                      // field width
   localparam int AXW = FRAC_BITS + 2;          // unit axis component, signed
   localparam int UW = AXW + 1;                 // derived up axis component, signed
   localparam int NIW = FW + AXW + 1;           // normalizer input component, signed

   // Normalizer internals
   localparam int NBW = $clog2(NIW + 1);        // bit length of a magnitude
   localparam int NB = 30;                      // scaled magnitude width, top bit at 29
   localparam int SQ_W = 2 * NB + 2;            // sum of three squares
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int RT_W = SQRT_STEPS;            // vector length
   localparam int DW = NB + FRAC_BITS + 1;      // dividend
   localparam int QW = FRAC_BITS + 1;           // quotient
   localparam int DIV_STEPS = QW;
   localparam int PRE_STAGES = 5;
   localparam int NORM_LAT = PRE_STAGES + SQRT_STEPS + DIV_STEPS + 2;

   localparam logic [1:0] ROW_LAST = 2'd3;
   localparam logic [FW-1:0] ONE_FIX = FW'(64'd1 << FRAC_BITS);

   typedef logic signed [NIW-1:0] ncomp_type;
   typedef ncomp_type [2:0] nvec_type;
   typedef logic signed [AXW-1:0] acomp_type;
   typedef acomp_type [2:0] avec_type;
   typedef logic [2:0][FW-1:0] wvec_type;

   typedef struct packed {
      logic signed [FW-1:0] eye_x;
      logic signed [FW-1:0] eye_y;
      logic signed [FW-1:0] eye_z;
      logic signed [FW-1:0] target_x;
      logic signed [FW-1:0] target_y;
      logic signed [FW-1:0] target_z;
      logic signed [FW-1:0] upvec_x;
      logic signed [FW-1:0] upvec_y;
      logic signed [FW-1:0] upvec_z;
   } req_type;

   typedef struct packed {
      logic [1:0] row_index;
      logic signed [FW-1:0] col0;
      logic signed [FW-1:0] col1;
      logic signed [FW-1:0] col2;
      logic signed [FW-1:0] col3;
      logic last_row;
      logic degenerate;
   } rsp_type;

endpackage

// File: sv/lav_isqrt.sv
module lav_isqrt (
   input  logic clock,
   input  logic en,
   input  logic [lav_pkg::SQ_W-1:0] rad,
   output logic [lav_pkg::RT_W-1:0] root
);
   import lav_pkg::*;

   localparam int XW = SQ_W + 1;

   logic [SQ_W-1:0] x_ff [SQRT_STEPS];
   logic [XW-1:0] r_ff [SQRT_STEPS];
   logic [SQ_W-1:0] x_in [SQRT_STEPS];
   logic [XW-1:0] r_in [SQRT_STEPS];

   // One result bit per stage: try r + bit against the remainder
   always_comb begin
      logic [SQ_W-1:0] xp;
      logic [XW-1:0] rp;
      logic [XW-1:0] bt;
      logic [XW-1:0] t;
      logic ge;
      for (int s = 0; s < SQRT_STEPS; s++) begin
         xp = rad;
         rp = '0;
         if (s > 0) begin
            xp = x_ff[s-1];
            rp = r_ff[s-1];
         end
         bt = XW'(1) << (2 * (SQRT_STEPS - 1 - s));
         t = rp + bt;
         ge = {1'b0, xp} >= t;
         x_in[s] = ge ? xp - t[SQ_W-1:0] : xp;
         r_in[s] = ge ? (rp >> 1) + bt : rp >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_STEPS; s++) begin
            x_ff[s] <= x_in[s];
            r_ff[s] <= r_in[s];
         end
      end
   end

   assign root = r_ff[SQRT_STEPS-1][RT_W-1:0];

endmodule

// File: sv/lav_div.sv
module lav_div (
   input  logic clock,
   input  logic en,
   input  logic [lav_pkg::DW-1:0] num,
   input  logic [lav_pkg::RT_W-1:0] den,
   output logic [lav_pkg::QW-1:0] quo
);
   import lav_pkg::*;

   logic [DW-1:0] rem_ff [DIV_STEPS];
   logic [RT_W-1:0] den_ff [DIV_STEPS];
   logic [QW-1:0] q_ff [DIV_STEPS];
   logic [DW-1:0] rem_in [DIV_STEPS];
   logic [RT_W-1:0] den_in [DIV_STEPS];
   logic [QW-1:0] q_in [DIV_STEPS];

   // Restoring division, quotient MSB first, one bit per stage
   always_comb begin
      logic [DW-1:0] rp;
      logic [RT_W-1:0] dp;
      logic [QW-1:0] qp;
      logic [DW:0] sub;
      logic ge;
      for (int s = 0; s < DIV_STEPS; s++) begin
         rp = num;
         dp = den;
         qp = '0;
         if (s > 0) begin
            rp = rem_ff[s-1];
            dp = den_ff[s-1];
            qp = q_ff[s-1];
         end
         sub = (DW + 1)'(dp) << (QW - 1 - s);
         ge = {1'b0, rp} >= sub;
         rem_in[s] = ge ? rp - sub[DW-1:0] : rp;
         den_in[s] = dp;
         q_in[s] = qp | (ge ? (QW'(1) << (QW - 1 - s)) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ff[s] <= rem_in[s];
            den_ff[s] <= den_in[s];
            q_ff[s] <= q_in[s];
         end
      end
   end

   assign quo = q_ff[DIV_STEPS-1];

endmodule

// File: sv/lav_norm.sv
module lav_norm (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_vld,
   input  lav_pkg::nvec_type vin,
   output logic out_vld,
   output lav_pkg::avec_type u,
   output logic zero
);
   import lav_pkg::*;

   typedef struct packed {
      logic [2:0][NB-1:0] m;
      logic [2:0] neg;
      logic zero;
   } sq_side_type;

   typedef struct packed {
      logic [2:0] neg;
      logic zero;
   } dv_side_type;

   logic [NORM_LAT-1:0] vld_ff;

   logic [2:0][NIW-1:0] mag1_ff, mag1_in;
   logic [2:0] neg1_ff, neg1_in;
   logic [NIW-1:0] or1_ff, or1_in;

   logic [2:0][NIW-1:0] mag2_ff;
   logic [2:0] neg2_ff;
   logic zero2_ff;
   logic [NBW-1:0] nb2_ff, nb2_in;

   logic [2:0][NB-1:0] m3_ff, m3_in;
   logic [2:0] neg3_ff;
   logic zero3_ff;

   logic [2:0][2*NB-1:0] sq4_ff, sq4_in;
   logic [2:0][NB-1:0] m4_ff;
   logic [2:0] neg4_ff;
   logic zero4_ff;

   logic [SQ_W-1:0] sum5_ff, sum5_in;
   sq_side_type side5_ff;

   sq_side_type sd_ff [SQRT_STEPS];
   logic [RT_W-1:0] len;

   logic [2:0][DW-1:0] num6_ff, num6_in;
   logic [RT_W-1:0] den6_ff;
   dv_side_type side6_ff;

   dv_side_type dd_ff [DIV_STEPS];
   logic [2:0][QW-1:0] quo;

   avec_type u7_ff, u7_in;
   logic zero7_ff;

   always_comb begin
      logic [NIW+NB-2:0] ext;
      logic [NBW-1:0] sh;
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = vin[i][NIW-1];
         mag1_in[i] = neg1_in[i] ? (~vin[i] + NIW'(1)) : vin[i];
      end
      or1_in = mag1_in[0] | mag1_in[1] | mag1_in[2];

      // bit length of the largest magnitude equals that of the OR
      nb2_in = '0;
      for (int i = 0; i < NIW; i++) begin
         if (or1_ff[i]) nb2_in = NBW'(i + 1);
      end

      // scale so the largest magnitude has its top bit at NB-1
      sh = nb2_ff - NBW'(1);
      for (int i = 0; i < 3; i++) begin
         ext = {mag2_ff[i], {(NB-1){1'b0}}};
         m3_in[i] = NB'(ext >> sh);
         sq4_in[i] = m3_ff[i] * m3_ff[i];
      end
      sum5_in = SQ_W'(sq4_ff[0]) + SQ_W'(sq4_ff[1]) + SQ_W'(sq4_ff[2]);

      for (int i = 0; i < 3; i++) begin
         num6_in[i] = DW'({sd_ff[SQRT_STEPS-1].m[i], {FRAC_BITS{1'b0}}}) + DW'(len >> 1);
      end

      for (int i = 0; i < 3; i++) begin
         if (dd_ff[DIV_STEPS-1].zero) begin
            u7_in[i] = '0;
         end else if (dd_ff[DIV_STEPS-1].neg[i]) begin
            u7_in[i] = -AXW'(quo[i]);
         end else begin
            u7_in[i] = AXW'(quo[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NORM_LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff <= mag1_in;
         neg1_ff <= neg1_in;
         or1_ff <= or1_in;

         mag2_ff <= mag1_ff;
         neg2_ff <= neg1_ff;
         zero2_ff <= or1_ff == '0;
         nb2_ff <= nb2_in;

         m3_ff <= m3_in;
         neg3_ff <= neg2_ff;
         zero3_ff <= zero2_ff;

         sq4_ff <= sq4_in;
         m4_ff <= m3_ff;
         neg4_ff <= neg3_ff;
         zero4_ff <= zero3_ff;

         sum5_ff <= sum5_in;
         side5_ff.m <= m4_ff;
         side5_ff.neg <= neg4_ff;
         side5_ff.zero <= zero4_ff;

         sd_ff[0] <= side5_ff;
         for (int s = 1; s < SQRT_STEPS; s++) sd_ff[s] <= sd_ff[s-1];

         num6_ff <= num6_in;
         den6_ff <= len;
         side6_ff.neg <= sd_ff[SQRT_STEPS-1].neg;
         side6_ff.zero <= sd_ff[SQRT_STEPS-1].zero;

         dd_ff[0] <= side6_ff;
         for (int s = 1; s < DIV_STEPS; s++) dd_ff[s] <= dd_ff[s-1];

         u7_ff <= u7_in;
         zero7_ff <= dd_ff[DIV_STEPS-1].zero;
      end
   end

   lav_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (sum5_ff),
      .root  (len)
   );

   for (genvar i = 0; i < 3; i++) begin : g_lane
      lav_div u_div (
         .clock (clock),
         .en    (en),
         .num   (num6_ff[i]),
         .den   (den6_ff),
         .quo   (quo[i])
      );
   end

   assign out_vld = vld_ff[NORM_LAT-1];
   assign u = u7_ff;
   assign zero = zero7_ff;

endmodule

// File: sv/look_at_view_matrix.sv
// Look-at view matrix builder. Each item carries an eye position, a target point and an
// up hint, all signed Q16.16, and produces four result items, rows 0 to 3 of the view
// matrix: right axis, new up axis, view axis (each with its translation -dot(eye, axis)
// in col3), then 0,0,0,1. Axes are unit vectors normalized by a fixed-point square root
// and divide; degenerate is set on all four rows when eye equals target or the up hint
// is zero or parallel to the view axis, and the affected axes come out as zeros. Every
// value saturates to the signed 32-bit range. The datapath is a fully pipelined chain of
// two normalizers (square root and divide units, one bit per stage) plus cross and dot
// product stages. A new item can be accepted every cycle unless the pipeline stalls,
// but each item drives four result items over the single result port, which sends a row
// every cycle while rsp_ready is high, so the sustained item rate is bounded by the rows.
// The whole pipeline stalls only when its last stage holds a finished matrix that the row
// sequencer cannot yet take.
module look_at_view_matrix (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  lav_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output lav_pkg::rsp_type rsp_data
);
   import lav_pkg::*;

   localparam int PW = FW + AXW;          // eye times axis
   localparam int PUW = FW + UW;          // eye times new up
   localparam int RW = PW - FRAC_BITS + 1;
   localparam int RUW = PUW - FRAC_BITS + 1;
   localparam int SW = RUW + 3;
   localparam int AAW = 2 * AXW;          // axis times axis

   typedef struct packed {
      wvec_type eye;
      wvec_type up;
   } side1_type;

   typedef struct packed {
      wvec_type eye;
      avec_type view;
      logic deg;
   } side2_type;

   typedef struct packed {
      logic [FW-1:0] c0;
      logic [FW-1:0] c1;
      logic [FW-1:0] c2;
      logic [FW-1:0] c3;
   } row_type;

   function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v);
      logic [63:0] m;
      logic [63:0] q;
      m = v[63] ? (~v + 64'd1) : v;
      q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      shr_rnd = v[63] ? $signed(-q) : $signed(q);
   endfunction

   function automatic logic [FW-1:0] sat_word(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = $signed((64'd1 << (WORD_BITS - 1)) - 64'd1);
      lo = -hi - 64'sd1;
      if (v > hi) sat_word = FW'(hi);
      else if (v < lo) sat_word = FW'(lo);
      else sat_word = FW'(v);
   endfunction

   logic adv;

   // input stage
   logic vld0_ff;
   wvec_type eye0_ff, up0_ff, eye_in, tgt_in, up_in;
   nvec_type d0_ff, d_in;

   // view normalizer
   logic vld_n1, zero1;
   avec_type view_n1;
   side1_type s1_ff [NORM_LAT];

   // cross product
   logic vx1_ff, vx2_ff;
   logic signed [5:0][PW-1:0] px1_ff, px1_in;
   wvec_type eye_x1_ff;
   avec_type view_x1_ff;
   logic deg_x1_ff;
   nvec_type c2_ff, c2_in;
   side2_type x2_side_ff;

   // right normalizer
   logic vld_n2, zero2;
   avec_type r_n2;
   side2_type s2_ff [NORM_LAT];

   // axes and dot products
   logic vu1_ff, vu2_ff, vu3_ff, vu4_ff, vu5_ff;
   avec_type right_in;
   avec_type right1_ff, view1_ff;
   wvec_type eye1_ff;
   logic deg1_ff;
   logic signed [5:0][AAW-1:0] pvr1_ff, pvr1_in;
   logic signed [2:0][PW-1:0] per1_ff, per1_in, pev1_ff, pev1_in;

   avec_type right2_ff, view2_ff;
   wvec_type eye2_ff;
   logic deg2_ff;
   logic signed [2:0][UW-1:0] unew2_ff, unew2_in;
   logic signed [2:0][RW-1:0] rer2_ff, rer2_in, rev2_ff, rev2_in;

   avec_type right3_ff, view3_ff;
   logic signed [2:0][UW-1:0] unew3_ff;
   logic deg3_ff;
   logic signed [2:0][PUW-1:0] peu3_ff, peu3_in;
   logic signed [SW-1:0] sr3_ff, sr3_in, sv3_ff, sv3_in;

   avec_type right4_ff, view4_ff;
   logic signed [2:0][UW-1:0] unew4_ff;
   logic deg4_ff;
   logic signed [2:0][RUW-1:0] reu4_ff, reu4_in;
   logic signed [SW-1:0] sr4_ff, sv4_ff;

   row_type [2:0] mat5_ff, mat5_in;
   logic deg5_ff;

   // row sequencer
   logic full_ff;
   logic [1:0] row_ff;
   row_type [2:0] mat_ff;
   logic deg_ff;
   logic load;

   // Stall the whole pipeline only when a finished matrix cannot move on
   assign adv = !vu5_ff || !full_ff || (rsp_ready && row_ff == ROW_LAST);
   assign load = vu5_ff && adv;
   assign req_ready = adv;

   // elements of the packed product arrays are unsigned, so sign them on every read
   always_comb begin
      logic signed [SW-1:0] su;
      eye_in = {req_data.eye_z, req_data.eye_y, req_data.eye_x};
      tgt_in = {req_data.target_z, req_data.target_y, req_data.target_x};
      up_in = {req_data.upvec_z, req_data.upvec_y, req_data.upvec_x};
      for (int i = 0; i < 3; i++) begin
         d_in[i] = NIW'($signed(eye_in[i])) - NIW'($signed(tgt_in[i]));
      end

      // cross(view, up)
      px1_in[0] = $signed(view_n1[1]) * $signed(s1_ff[NORM_LAT-1].up[2]);
      px1_in[1] = $signed(view_n1[2]) * $signed(s1_ff[NORM_LAT-1].up[1]);
      px1_in[2] = $signed(view_n1[2]) * $signed(s1_ff[NORM_LAT-1].up[0]);
      px1_in[3] = $signed(view_n1[0]) * $signed(s1_ff[NORM_LAT-1].up[2]);
      px1_in[4] = $signed(view_n1[0]) * $signed(s1_ff[NORM_LAT-1].up[1]);
      px1_in[5] = $signed(view_n1[1]) * $signed(s1_ff[NORM_LAT-1].up[0]);
      for (int i = 0; i < 3; i++) begin
         c2_in[i] = NIW'($signed(px1_ff[2*i])) - NIW'($signed(px1_ff[2*i+1]));
      end

      // right = -normalized cross; products for new up and dots
      for (int i = 0; i < 3; i++) right_in[i] = -r_n2[i];
      pvr1_in[0] = $signed(s2_ff[NORM_LAT-1].view[1]) * $signed(right_in[2]);
      pvr1_in[1] = $signed(s2_ff[NORM_LAT-1].view[2]) * $signed(right_in[1]);
      pvr1_in[2] = $signed(s2_ff[NORM_LAT-1].view[2]) * $signed(right_in[0]);
      pvr1_in[3] = $signed(s2_ff[NORM_LAT-1].view[0]) * $signed(right_in[2]);
      pvr1_in[4] = $signed(s2_ff[NORM_LAT-1].view[0]) * $signed(right_in[1]);
      pvr1_in[5] = $signed(s2_ff[NORM_LAT-1].view[1]) * $signed(right_in[0]);
      for (int i = 0; i < 3; i++) begin
         per1_in[i] = $signed(s2_ff[NORM_LAT-1].eye[i]) * $signed(right_in[i]);
         pev1_in[i] = $signed(s2_ff[NORM_LAT-1].eye[i]) * $signed(s2_ff[NORM_LAT-1].view[i]);
      end

      // new up axis, rounded eye terms
      for (int i = 0; i < 3; i++) begin
         unew2_in[i] = UW'(shr_rnd(64'($signed(pvr1_ff[2*i])) -
                                   64'($signed(pvr1_ff[2*i+1]))));
         rer2_in[i] = RW'(shr_rnd(64'($signed(per1_ff[i]))));
         rev2_in[i] = RW'(shr_rnd(64'($signed(pev1_ff[i]))));
      end

      for (int i = 0; i < 3; i++) begin
         peu3_in[i] = $signed(eye2_ff[i]) * $signed(unew2_ff[i]);
      end
      sr3_in = -(SW'($signed(rer2_ff[0])) + SW'($signed(rer2_ff[1])) +
                 SW'($signed(rer2_ff[2])));
      sv3_in = -(SW'($signed(rev2_ff[0])) + SW'($signed(rev2_ff[1])) +
                 SW'($signed(rev2_ff[2])));

      for (int i = 0; i < 3; i++) begin
         reu4_in[i] = RUW'(shr_rnd(64'($signed(peu3_ff[i]))));
      end

      // saturate into the three axis rows
      su = -(SW'($signed(reu4_ff[0])) + SW'($signed(reu4_ff[1])) +
             SW'($signed(reu4_ff[2])));
      mat5_in[0].c0 = sat_word(64'(right4_ff[0]));
      mat5_in[0].c1 = sat_word(64'(right4_ff[1]));
      mat5_in[0].c2 = sat_word(64'(right4_ff[2]));
      mat5_in[0].c3 = sat_word(64'(sr4_ff));
      mat5_in[1].c0 = sat_word(64'($signed(unew4_ff[0])));
      mat5_in[1].c1 = sat_word(64'($signed(unew4_ff[1])));
      mat5_in[1].c2 = sat_word(64'($signed(unew4_ff[2])));
      mat5_in[1].c3 = sat_word(64'(su));
      mat5_in[2].c0 = sat_word(64'(view4_ff[0]));
      mat5_in[2].c1 = sat_word(64'(view4_ff[1]));
      mat5_in[2].c2 = sat_word(64'(view4_ff[2]));
      mat5_in[2].c3 = sat_word(64'(sv4_ff));
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vx1_ff <= 1'b0;
         vx2_ff <= 1'b0;
         vu1_ff <= 1'b0;
         vu2_ff <= 1'b0;
         vu3_ff <= 1'b0;
         vu4_ff <= 1'b0;
         vu5_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
         vx1_ff <= vld_n1;
         vx2_ff <= vx1_ff;
         vu1_ff <= vld_n2;
         vu2_ff <= vu1_ff;
         vu3_ff <= vu2_ff;
         vu4_ff <= vu3_ff;
         vu5_ff <= vu4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         eye0_ff <= eye_in;
         up0_ff <= up_in;
         d0_ff <= d_in;

         s1_ff[0].eye <= eye0_ff;
         s1_ff[0].up <= up0_ff;
         for (int s = 1; s < NORM_LAT; s++) s1_ff[s] <= s1_ff[s-1];

         px1_ff <= px1_in;
         eye_x1_ff <= s1_ff[NORM_LAT-1].eye;
         view_x1_ff <= view_n1;
         deg_x1_ff <= zero1;

         c2_ff <= c2_in;
         x2_side_ff.eye <= eye_x1_ff;
         x2_side_ff.view <= view_x1_ff;
         x2_side_ff.deg <= deg_x1_ff;

         s2_ff[0] <= x2_side_ff;
         for (int s = 1; s < NORM_LAT; s++) s2_ff[s] <= s2_ff[s-1];

         right1_ff <= right_in;
         view1_ff <= s2_ff[NORM_LAT-1].view;
         eye1_ff <= s2_ff[NORM_LAT-1].eye;
         deg1_ff <= s2_ff[NORM_LAT-1].deg | zero2;
         pvr1_ff <= pvr1_in;
         per1_ff <= per1_in;
         pev1_ff <= pev1_in;

         right2_ff <= right1_ff;
         view2_ff <= view1_ff;
         eye2_ff <= eye1_ff;
         deg2_ff <= deg1_ff;
         unew2_ff <= unew2_in;
         rer2_ff <= rer2_in;
         rev2_ff <= rev2_in;

         right3_ff <= right2_ff;
         view3_ff <= view2_ff;
         unew3_ff <= unew2_ff;
         deg3_ff <= deg2_ff;
         peu3_ff <= peu3_in;
         sr3_ff <= sr3_in;
         sv3_ff <= sv3_in;

         right4_ff <= right3_ff;
         view4_ff <= view3_ff;
         unew4_ff <= unew3_ff;
         deg4_ff <= deg3_ff;
         reu4_ff <= reu4_in;
         sr4_ff <= sr3_ff;
         sv4_ff <= sv3_ff;

         mat5_ff <= mat5_in;
         deg5_ff <= deg4_ff;
      end
   end

   // Row sequencer: hold one finished matrix, send it a row at a time
   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         row_ff <= '0;
      end else if (load) begin
         full_ff <= 1'b1;
         row_ff <= '0;
      end else if (full_ff && rsp_ready) begin
         if (row_ff == ROW_LAST) full_ff <= 1'b0;
         row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mat_ff <= mat5_ff;
         deg_ff <= deg5_ff;
      end
   end

   always_comb begin
      rsp_data.row_index = row_ff;
      rsp_data.last_row = row_ff == ROW_LAST;
      rsp_data.degenerate = deg_ff;
      case (row_ff)
         2'd0: begin
            rsp_data.col0 = mat_ff[0].c0;
            rsp_data.col1 = mat_ff[0].c1;
            rsp_data.col2 = mat_ff[0].c2;
            rsp_data.col3 = mat_ff[0].c3;
         end
         2'd1: begin
            rsp_data.col0 = mat_ff[1].c0;
            rsp_data.col1 = mat_ff[1].c1;
            rsp_data.col2 = mat_ff[1].c2;
            rsp_data.col3 = mat_ff[1].c3;
         end
         2'd2: begin
            rsp_data.col0 = mat_ff[2].c0;
            rsp_data.col1 = mat_ff[2].c1;
            rsp_data.col2 = mat_ff[2].c2;
            rsp_data.col3 = mat_ff[2].c3;
         end
         default: begin
            rsp_data.col0 = '0;
            rsp_data.col1 = '0;
            rsp_data.col2 = '0;
            rsp_data.col3 = ONE_FIX;
         end
      endcase
   end

   assign rsp_valid = full_ff;

   lav_norm u_norm_view (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (vld0_ff),
      .vin     (d0_ff),
      .out_vld (vld_n1),
      .u       (view_n1),
      .zero    (zero1)
   );

   lav_norm u_norm_right (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .in_vld  (vx2_ff),
      .vin     (c2_ff),
      .out_vld (vld_n2),
      .u       (r_n2),
      .zero    (zero2)
   );

`ifndef SYNTHESIS
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_row == (rsp_data.row_index == ROW_LAST)))
      else $error("last_row does not match row_index");

   a_row_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last_row) |=>
      (rsp_valid && rsp_data.row_index == $past(rsp_data.row_index) + 2'd1))
      else $error("rows of one matrix not sent in order");

   a_deg_rows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last_row) |=>
      (rsp_data.degenerate == $past(rsp_data.degenerate)))
      else $error("degenerate flag changed within one matrix");

   a_fixed_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_row) |->
      (rsp_data.col0 == '0 && rsp_data.col1 == '0 && rsp_data.col2 == '0 &&
       rsp_data.col3 == ONE_FIX))
      else $error("fourth row is not 0,0,0,1");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !vu5_ff |-> req_ready)
      else $error("pipeline stalled with an empty last stage");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import lav_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_WAIT = 17;
   localparam int NUM_RANDOM = 160;
   localparam int DRAIN_CYCLES = 300;
   // longest quiet stretch: pipeline latency plus four rows each behind a full stall
   localparam int STALL_LIMIT = 2000;
   localparam logic signed [31:0] MAX_FIX = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_FIX = 32'sh80000000;
   localparam logic signed [31:0] ONE = 32'sh00010000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type rows_due[$];
   int error_count = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   always #HALF_PERIOD clock = ~clock;

   look_at_view_matrix i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // ---------------------------------------------------------------- prediction

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(64'd0 - 64'(v)) : v;
   endfunction

   // shift right by the fraction width, rounding half away from zero
   function automatic longint round_frac(longint v);
      longint unsigned m;
      m = (abs64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic [31:0] clamp_word(longint v);
      if (v > longint'(MAX_FIX)) return MAX_FIX;
      if (v < longint'(MIN_FIX)) return MIN_FIX;
      return v[31:0];
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit vector; returns 0 on zero length and clears the output
   function automatic bit unit_vector(input longint v[3], output longint u[3]);
      longint unsigned m[3], top, sum, len, q;
      int nbits;
      top = 0;
      sum = 0;
      nbits = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = abs64(v[i]);
         if (m[i] > top) top = m[i];
      end
      if (top == 0) begin
         u = '{0, 0, 0};
         return 1'b0;
      end
      while (nbits < 64 && (top >> nbits) != 0) nbits++;
      for (int i = 0; i < 3; i++) begin
         if (nbits > 30) m[i] >>= (nbits - 30);
         else m[i] <<= (30 - nbits);
         sum += m[i] * m[i];
      end
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC_BITS) + len / 2) / len;
         u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   task automatic predict_matrix(input req_type rq);
      longint eye[3], tgt[3], up[3], d[3], view[3], c[3], r[3], right[3], unew[3];
      longint rows[4][4];
      longint s;
      bit degen;
      rsp_type row;
      eye = '{rq.eye_x, rq.eye_y, rq.eye_z};
      tgt = '{rq.target_x, rq.target_y, rq.target_z};
      up = '{rq.upvec_x, rq.upvec_y, rq.upvec_z};
      for (int i = 0; i < 3; i++) d[i] = eye[i] - tgt[i];
      degen = !unit_vector(d, view);
      c[0] = view[1] * up[2] - view[2] * up[1];
      c[1] = view[2] * up[0] - view[0] * up[2];
      c[2] = view[0] * up[1] - view[1] * up[0];
      if (!unit_vector(c, r)) degen = 1'b1;
      for (int i = 0; i < 3; i++) right[i] = -r[i];
      unew[0] = round_frac(view[1] * right[2] - view[2] * right[1]);
      unew[1] = round_frac(view[2] * right[0] - view[0] * right[2]);
      unew[2] = round_frac(view[0] * right[1] - view[1] * right[0]);
      for (int i = 0; i < 3; i++) begin
         rows[0][i] = right[i];
         rows[1][i] = unew[i];
         rows[2][i] = view[i];
         rows[3][i] = 0;
      end
      for (int k = 0; k < 3; k++) begin
         s = 0;
         for (int i = 0; i < 3; i++) s += round_frac(eye[i] * rows[k][i]);
         rows[k][3] = -s;
      end
      rows[3][3] = 64'd1 << FRAC_BITS;
      for (int k = 0; k < 4; k++) begin
         row.row_index = k[1:0];
         row.col0 = clamp_word(rows[k][0]);
         row.col1 = clamp_word(rows[k][1]);
         row.col2 = clamp_word(rows[k][2]);
         row.col3 = clamp_word(rows[k][3]);
         row.last_row = (k[1:0] == ROW_LAST);
         row.degenerate = degen;
         rows_due.push_back(row);
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   typedef struct {
      req_type rq;
      bit typed;       // expected rows below are given by hand
      rsp_type fixed[4];
   } vector_row;

   function automatic req_type mk(logic [31:0] ex, ey, ez, tx, ty, tz, ux, uy, uz);
      req_type r;
      r = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
      return r;
   endfunction

   // degenerate matrix: all axes zero, translation zero, last row 0,0,0,1
   function automatic vector_row zero_axes(req_type rq);
      vector_row v;
      v.rq = rq;
      v.typed = 1'b1;
      for (int k = 0; k < 4; k++)
         v.fixed[k] = '{k[1:0], 0, 0, 0, (k == 3) ? ONE : 0, k == 3, 1'b1};
      return v;
   endfunction

   function automatic vector_row by_model(req_type rq);
      vector_row v;
      v.rq = rq;
      v.typed = 1'b0;
      return v;
   endfunction

   vector_row directed[$];

   initial begin
      vector_row v;
      // identity look-down: eye (0,0,1), target origin, up +y
      v.rq = mk(0, 0, ONE, 0, 0, 0, 0, ONE, 0);
      v.typed = 1'b1;
      v.fixed[0] = '{2'd0, ONE, 0, 0, 0, 1'b0, 1'b0};
      v.fixed[1] = '{2'd1, 0, ONE, 0, 0, 1'b0, 1'b0};
      v.fixed[2] = '{2'd2, 0, 0, ONE, -ONE, 1'b0, 1'b0};
      v.fixed[3] = '{2'd3, 0, 0, 0, ONE, 1'b1, 1'b0};
      directed.push_back(v);
      // eye equals target
      directed.push_back(zero_axes(mk(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE,
                                      0, ONE, 0)));
      directed.push_back(zero_axes(mk(0, 0, 0, 0, 0, 0, 0, 0, 0)));
      directed.push_back(zero_axes(mk(MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX,
                                      MIN_FIX, MAX_FIX, MAX_FIX, MAX_FIX)));
      // zero up hint, up parallel to view: view axis still valid, so model-checked
      directed.push_back(by_model(mk(0, 0, ONE, 0, 0, 0, 0, 0, 0)));
      directed.push_back(by_model(mk(0, 0, ONE, 0, 0, 0, 0, 0, 5 * ONE)));
      directed.push_back(by_model(mk(ONE, ONE, 0, 0, 0, 0, -ONE, -ONE, 0)));
      // field extremes and saturating translation
      directed.push_back(by_model(mk(MAX_FIX, MAX_FIX, MAX_FIX, MIN_FIX, MIN_FIX,
                                     MIN_FIX, 0, ONE, 0)));
      directed.push_back(by_model(mk(MIN_FIX, MAX_FIX, MIN_FIX, MAX_FIX, MIN_FIX,
                                     MAX_FIX, MIN_FIX, MIN_FIX, MAX_FIX)));
      directed.push_back(by_model(mk(MAX_FIX, 0, 0, 0, MAX_FIX, 0, MIN_FIX, 0, MAX_FIX)));
      directed.push_back(by_model(mk(-1, -1, -1, 1, 1, 1, -1, 1, -1)));
      directed.push_back(by_model(mk(1, 0, 0, 0, 0, 0, 0, 1, 0)));
      directed.push_back(by_model(mk(32'hffffffff, 32'h7fff0000, 32'h0000ffff,
                                     32'haaaaaaaa, 32'h55555555, 32'h80000001,
                                     32'h0f0f0f0f, 32'hf0f0f0f0, 32'h00000001)));
      directed.push_back(by_model(mk(10 * ONE, 3 * ONE, -7 * ONE, -2 * ONE, ONE, 4 * ONE,
                                     0, ONE, 0)));
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? MAX_FIX : MIN_FIX;
         2: return $urandom_range(0, 3);
         default: return 32'($signed($urandom_range(0, 400)) - 200) <<< $urandom_range(8, 16);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type rq;
      rq = mk(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord());
      // occasionally force the degenerate paths
      case ($urandom_range(0, 9))
         0: {rq.target_x, rq.target_y, rq.target_z} = {rq.eye_x, rq.eye_y, rq.eye_z};
         1: {rq.upvec_x, rq.upvec_y, rq.upvec_z} = '0;
         2: begin
            rq.target_x = 0; rq.target_y = 0; rq.target_z = 0;
            rq.upvec_x = rq.eye_x; rq.upvec_y = rq.eye_y; rq.upvec_z = rq.eye_z;
         end
         default: ;
      endcase
      return rq;
   endfunction

   // drop valid for a random gap, then hold the item until accepted
   task automatic send_item(input req_type rq);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_matrix(rq);
   endtask

   initial begin
      vector_row v;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[n]) begin
         v = directed[n];
         send_item(v.rq);
         if (v.typed) begin
            // replace the prediction with the hand-typed rows
            repeat (4) void'(rows_due.pop_back());
            for (int k = 0; k < 4; k++) rows_due.push_back(v.fixed[k]);
         end
      end
      for (int n = 0; n < NUM_RANDOM; n++) send_item(random_request());
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // ---------------------------------------------------------------- result side

   // redraw the ready pattern per item: some stretches always ready
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rows_due.size() == 0) begin
            $error("unexpected row item: %p", rsp_data);
            error_count++;
         end else begin
            want = rows_due.pop_front();
            if (rsp_data.row_index !== want.row_index) begin
               $error("row_index: expected %0d, got %0d", want.row_index, rsp_data.row_index);
               error_count++;
            end
            if (rsp_data.col0 !== want.col0) begin
               $error("col0: expected %0d, got %0d", want.col0, rsp_data.col0);
               error_count++;
            end
            if (rsp_data.col1 !== want.col1) begin
               $error("col1: expected %0d, got %0d", want.col1, rsp_data.col1);
               error_count++;
            end
            if (rsp_data.col2 !== want.col2) begin
               $error("col2: expected %0d, got %0d", want.col2, rsp_data.col2);
               error_count++;
            end
            if (rsp_data.col3 !== want.col3) begin
               $error("col3: expected %0d, got %0d", want.col3, rsp_data.col3);
               error_count++;
            end
            if (rsp_data.last_row !== want.last_row) begin
               $error("last_row: expected %0b, got %0b", want.last_row, rsp_data.last_row);
               error_count++;
            end
            if (rsp_data.degenerate !== want.degenerate) begin
               $error("degenerate: expected %0b, got %0b", want.degenerate,
                      rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- end of run

   // count cycles with no handshake on either side
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      while (rows_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
